>>> rtl/mcr_pkg.sv
package mcr_pkg;

  localparam int unsigned JobDepth = 2;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  localparam logic       ReqStart = 1'b0;
  localparam logic       ReqStep  = 1'b1;

  localparam logic [1:0] CfgImageWidth    = 2'd0;
  localparam logic [1:0] CfgImageHeight   = 2'd1;
  localparam logic [1:0] CfgBytesPerPixel = 2'd2;

  localparam logic [1:0] Bpp888 = 2'd3;

  typedef enum logic {
    JobNoWrite,
    JobStep
  } job_kind_e;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [1:0]  bpp;
  } cfg_t;

  // cx, cy, x, y hold two's complement values
  typedef struct packed {
    job_kind_e   kind;
    logic        done;
    logic        fill;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] color;
  } job_t;

  typedef struct packed {
    logic        write_valid;
    logic [9:0]  row;
    logic [9:0]  col_first;
    logic [9:0]  col_last;
    logic [21:0] byte_address;
    logic [23:0] pixel_data;
    logic        last;
    logic        circle_done;
  } result_t;

endpackage

>>> rtl/mcr_front.sv
module mcr_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             req_type_i,
  input  logic [11:0]      center_x_i,
  input  logic [11:0]      center_y_i,
  input  logic [9:0]       radius_i,
  input  logic             fill_i,
  input  logic [15:0]      color_i,
  output logic             job_push_o,
  output mcr_pkg::job_t    job_o
);
  import mcr_pkg::*;

  logic               busy_q, busy_d;
  logic signed [11:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [11:0] minor_q, minor_d, major_q, major_d;
  logic signed [15:0] dec_q, dec_d;
  logic [15:0]        color_q, color_d;
  logic               fill_q, fill_d;

  logic signed [11:0] x1n, yn;
  logic signed [17:0] dn_w;
  logic               step_done;

  // midpoint update
  always_comb begin
    x1n = minor_q + 12'sd1;
    if (dec_q > 16'sd0) begin
      yn   = major_q - 12'sd1;
      dn_w = 18'(dec_q) + (18'(x1n - yn) <<< 2) + 18'sd10;
    end else begin
      yn   = major_q;
      dn_w = 18'(dec_q) + (18'(x1n) <<< 2) + 18'sd6;
    end
    step_done = yn < x1n;
  end

  always_comb begin
    busy_d  = busy_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    minor_d = minor_q;
    major_d = major_q;
    dec_d   = dec_q;
    color_d = color_q;
    fill_d  = fill_q;

    job_o.kind  = JobNoWrite;
    job_o.done  = 1'b0;
    job_o.fill  = fill_q;
    job_o.cx    = cx_q;
    job_o.cy    = cy_q;
    job_o.x     = minor_q;
    job_o.y     = major_q;
    job_o.color = color_q;

    if (accept_i) begin
      if (req_type_i == ReqStart) begin
        busy_d  = 1'b1;
        cx_d    = $signed(center_x_i);
        cy_d    = $signed(center_y_i);
        minor_d = 12'sd0;
        major_d = $signed({2'b00, radius_i});
        dec_d   = 16'sd3 - $signed({5'b00000, radius_i, 1'b0});
        color_d = color_i;
        fill_d  = fill_i;
      end else if (!busy_q) begin
        job_o.done = 1'b1;
      end else begin
        job_o.kind = JobStep;
        job_o.done = step_done;
        minor_d    = x1n;
        major_d    = yn;
        dec_d      = dn_w[15:0];
        busy_d     = !step_done;
      end
    end
  end

  assign job_push_o = accept_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      minor_q <= '0;
      major_q <= '0;
      dec_q   <= '0;
      color_q <= '0;
      fill_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      minor_q <= minor_d;
      major_q <= major_d;
      dec_q   <= dec_d;
      color_q <= color_d;
      fill_q  <= fill_d;
    end
  end

endmodule

>>> rtl/mcr_job_fifo.sv
module mcr_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcr_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  output mcr_pkg::job_t job_o,
  input  logic          pop_i
);
  import mcr_pkg::*;

  job_t               mem_q [JobDepth];
  logic [JobPtrW-1:0] wr_q, rd_q;
  logic [JobCntW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == JobCntW'(JobDepth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + JobCntW'(do_push) - JobCntW'(do_pop);
    end
  end

endmodule

>>> rtl/mcr_back.sv
module mcr_back #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mcr_pkg::cfg_t    cfg_i,
  input  logic             job_valid_i,
  input  mcr_pkg::job_t    job_i,
  output logic             job_pop_o,
  output mcr_pkg::result_t res_o,
  output logic             res_empty_o,
  input  logic             res_pop_i
);
  import mcr_pkg::*;

  localparam logic [12:0] MaxDim = 13'(MAX_DIM);

  typedef struct packed {
    logic [13:0] row;
    logic [13:0] lo;
    logic [13:0] hi;
  } cand_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] row;
    logic [11:0] first;
    logic [11:0] last;
  } clip_t;

  typedef struct packed {
    logic        wv;
    logic [11:0] row;
    logic [11:0] first;
    logic [11:0] lastc;
    logic        last;
    logic        done;
    logic [15:0] color;
  } stage_t;

  function automatic cand_t cand_of(job_t j, logic [2:0] k);
    logic signed [13:0] cx, cy, x, y, row, lo, hi, col;
    cand_t              c;
    cx = $signed({{2{j.cx[11]}}, j.cx});
    cy = $signed({{2{j.cy[11]}}, j.cy});
    x  = $signed({{2{j.x[11]}}, j.x});
    y  = $signed({{2{j.y[11]}}, j.y});
    if (j.fill) begin
      if (!k[1]) begin
        row = k[0] ? cy - x : cy + x;
        lo  = cx - y;
        hi  = cx + y;
      end else begin
        row = k[0] ? cy - y : cy + y;
        lo  = cx - x;
        hi  = cx + x;
      end
    end else begin
      if (!k[2]) begin
        col = k[0] ? cx - x : cx + x;
        row = k[1] ? cy - y : cy + y;
      end else begin
        col = k[0] ? cx - y : cx + y;
        row = k[1] ? cy - x : cy + x;
      end
      lo = col;
      hi = col;
    end
    c.row = row;
    c.lo  = lo;
    c.hi  = hi;
    return c;
  endfunction

  function automatic clip_t clip_of(cand_t c, logic [12:0] w, logic [12:0] h);
    logic signed [14:0] row, lo, hi, wm1, hs;
    clip_t              r;
    row = $signed({c.row[13], c.row});
    lo  = $signed({c.lo[13], c.lo});
    hi  = $signed({c.hi[13], c.hi});
    hs  = $signed({2'b00, h});
    wm1 = $signed({2'b00, w}) - 15'sd1;
    if (lo < 15'sd0) begin
      lo = 15'sd0;
    end
    if (hi > wm1) begin
      hi = wm1;
    end
    r.ok    = (row >= 15'sd0) && (row < hs) && (lo <= hi);
    r.row   = row[11:0];
    r.first = lo[11:0];
    r.last  = hi[11:0];
    return r;
  endfunction

  function automatic logic [2:0] low_idx(logic [7:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  logic [12:0] eff_w, eff_h;
  assign eff_w = ({2'b00, cfg_i.width} > MaxDim) ? MaxDim : {2'b00, cfg_i.width};
  assign eff_h = ({2'b00, cfg_i.height} > MaxDim) ? MaxDim : {2'b00, cfg_i.height};

  // sequencer over the mirror candidates of the current job
  job_t        job_q, job_d;
  logic [7:0]  mask_q, mask_d, new_mask;
  logic        nw_q, nw_d;
  logic        active, issue, last_issue, load;
  logic [2:0]  k_sel;
  logic [7:0]  k_hot;
  clip_t       sel_clip;
  clip_t       mask_clip;

  logic        s1_v_q, s2_v_q;
  stage_t      s1_q, s1_d, s2_q;
  logic [24:0] prod_q;

  result_t             oq_mem_q [OutDepth];
  logic [OutPtrW-1:0]  oq_wr_q, oq_rd_q;
  logic [OutCntW-1:0]  oq_cnt_q;
  logic [3:0]          occupancy;
  logic                oq_pop;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask_clip   = clip_of(cand_of(job_i, 3'(i)), eff_w, eff_h);
      new_mask[i] = mask_clip.ok && (!job_i.fill || (i < 4));
    end
  end

  assign occupancy  = 4'(oq_cnt_q) + 4'(s1_v_q) + 4'(s2_v_q);
  assign active     = nw_q || (mask_q != '0);
  assign issue      = active && (occupancy < 4'(OutDepth));
  assign k_sel      = low_idx(mask_q);
  assign k_hot      = 8'b1 << k_sel;
  assign last_issue = nw_q || ((mask_q & ~k_hot) == '0);
  assign load       = job_valid_i && (!active || (issue && last_issue));
  assign job_pop_o  = load;
  assign sel_clip   = clip_of(cand_of(job_q, k_sel), eff_w, eff_h);

  always_comb begin
    job_d  = job_q;
    mask_d = mask_q;
    nw_d   = nw_q;
    if (issue) begin
      if (nw_q) begin
        nw_d = 1'b0;
      end else begin
        mask_d = mask_q & ~k_hot;
      end
    end
    if (load) begin
      job_d  = job_i;
      mask_d = (job_i.kind == JobStep) ? new_mask : '0;
      nw_d   = (job_i.kind == JobNoWrite) || (new_mask == '0);
    end

    s1_d.wv    = !nw_q;
    s1_d.row   = nw_q ? '0 : sel_clip.row;
    s1_d.first = nw_q ? '0 : sel_clip.first;
    s1_d.lastc = nw_q ? '0 : sel_clip.last;
    s1_d.last  = last_issue;
    s1_d.done  = job_q.done;
    s1_d.color = job_q.color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      nw_q   <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      nw_q   <= nw_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    s1_q   <= s1_d;
    s2_q   <= s1_q;
    prod_q <= 25'(s1_q.row) * 25'(eff_w);
  end

  // address and pixel formatting
  logic [24:0] base, addr;
  logic [23:0] pix;
  result_t     res_new;

  always_comb begin
    base = prod_q + {13'd0, s2_q.first};
    if (cfg_i.bpp == Bpp888) begin
      addr = base + (base << 1);
      pix  = {s2_q.color[4:0], 3'b000, s2_q.color[10:5], 2'b00,
              s2_q.color[15:11], 3'b000};
    end else begin
      addr = base << 1;
      pix  = {8'h00, s2_q.color};
    end
    res_new.write_valid  = s2_q.wv;
    res_new.row          = s2_q.row[9:0];
    res_new.col_first    = s2_q.first[9:0];
    res_new.col_last     = s2_q.lastc[9:0];
    res_new.byte_address = s2_q.wv ? addr[21:0] : '0;
    res_new.pixel_data   = s2_q.wv ? pix : '0;
    res_new.last         = s2_q.last;
    res_new.circle_done  = s2_q.done;
  end

  assign res_empty_o = oq_cnt_q == '0;
  assign res_o       = oq_mem_q[oq_rd_q];
  assign oq_pop      = res_pop_i && !res_empty_o;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      oq_mem_q[oq_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_v_q) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OutCntW'(s2_v_q) - OutCntW'(oq_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= 4'(OutDepth))
    else $error("result queue overrun");

  a_nw_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(nw_q && (mask_q != '0)))
    else $error("empty result pending alongside writes");

  a_write_on_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s1_q.wv) |-> ({1'b0, s1_q.row} < eff_h) &&
                            (s1_q.first <= s1_q.lastc))
    else $error("write issued off the image");

endmodule

>>> rtl/midpoint_circle_rasterizer.sv
// Throughput: one result per cycle while the result queue, counting results
// in flight, has room; a step request yields max(1, kept writes) results,
// at most 8 in outline and 4 in filled mode, all issued through the single
// address/multiplier pipe feeding the result queue.
// Reset: asynchronous, clears all queues and circle state; image size returns
// to 320x240 at 2 bytes per pixel.
module midpoint_circle_rasterizer #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [11:0] center_x_i,
  input  logic [11:0] center_y_i,
  input  logic [9:0]  radius_i,
  input  logic        fill_i,
  input  logic [15:0] color_i,
  output logic        empty,
  input  logic        pop,
  output logic        write_valid_o,
  output logic [9:0]  row_o,
  output logic [9:0]  col_first_o,
  output logic [9:0]  col_last_o,
  output logic [21:0] byte_address_o,
  output logic [23:0] pixel_data_o,
  output logic        last_o,
  output logic        circle_done_o,
  input  logic        cfg_write_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import mcr_pkg::*;

  cfg_t    cfg_q;
  job_t    fr_job, bk_job;
  logic    fr_push, bk_valid, bk_pop, accept;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= 11'd320;
      cfg_q.height <= 11'd240;
      cfg_q.bpp    <= 2'd2;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CfgImageWidth:    cfg_q.width  <= cfg_data_i;
        CfgImageHeight:   cfg_q.height <= cfg_data_i;
        CfgBytesPerPixel: cfg_q.bpp    <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .fill_i     (fill_i),
    .color_i    (color_i),
    .job_push_o (fr_push),
    .job_o      (fr_job)
  );

  mcr_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .job_i   (fr_job),
    .full_o  (full),
    .valid_o (bk_valid),
    .job_o   (bk_job),
    .pop_i   (bk_pop)
  );

  mcr_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (bk_valid),
    .job_i       (bk_job),
    .job_pop_o   (bk_pop),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

  assign write_valid_o  = res.write_valid;
  assign row_o          = res.row;
  assign col_first_o    = res.col_first;
  assign col_last_o     = res.col_last;
  assign byte_address_o = res.byte_address;
  assign pixel_data_o   = res.pixel_data;
  assign last_o         = res.last;
  assign circle_done_o  = res.circle_done;

endmodule
